// ----- src/htw_pkg.sv -----
// Package for the hierarchical timing wheel: types, codes and constants.
// No dependencies.
package htw_pkg;
  localparam int NumTimers = 32;
  localparam int IdW = 5;
  localparam int NearWidth = 8;
  localparam int WheelWidth = 6;
  localparam int WheelBits = NearWidth + 4 * WheelWidth;
  localparam logic [32:0] Horizon = (WheelBits >= 32) ? 33'h0_ffff_ffff :
                                    ((33'd1 << WheelBits) - 33'd1);

  typedef enum logic [2:0] {
    REQ_TICK = 3'd0, REQ_ADD = 3'd1, REQ_KILL = 3'd2, REQ_PAUSE = 3'd3, REQ_RESUME = 3'd4
  } req_t;

  typedef enum logic [1:0] {ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_PAUSE = 2'd2} tstat_t;

  typedef enum logic [2:0] {
    C_IDLE, C_RD, C_EXEC, C_SCAN_RD, C_SCAN, C_OUT, C_DONE
  } cstate_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request
    logic rd;         // read memories at selected id
    logic exec;       // perform request update
    logic scan_rd;    // read memories at scan index
    logic scan_do;    // evaluate scanned timer
    logic scan_inc;   // advance scan index
    logic tick_done;  // advance counter
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic hit;        // scanned timer fires
    logic scan_last;  // scan index at final timer
  } sts_t;
endpackage

// ----- src/hierarchical_timing_wheel.sv -----
// Top level of the hierarchical timing wheel timer block.
// Depends on htw_pkg, htw_ctrl and htw_dp.
//
// Thirty-two software timers. One request at a time: add, kill, pause and
// resume pass through the states C_IDLE, C_RD, C_EXEC and C_DONE, the last of
// them the output transfer. A tick scans all timers in ascending number, each
// through a read, a scan and an output state on the single read port of the
// timer memories, and waits while a result is held by out_stall; each firing
// timer gives one result, then a closing result with last set. A tick fires
// timers whose expiry equals the counter and re-arms repeating timers at counter+1+interval.
module hierarchical_timing_wheel import htw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [4:0]  in_timer_id,
  input  logic signed [31:0] in_repeat_count,
  input  logic [31:0] in_interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic        out_fired,
  output logic [4:0]  out_fired_timer,
  output logic        out_last
);
  cmd_t cmd;
  sts_t sts;
  logic res_ok, res_fired;
  logic [4:0] scan_id;

  // sequence requests and the scan
  htw_ctrl u_ctrl (
    .clk, .rst_n, .sts, .cmd, .in_valid, .in_stall,
    .res_valid(out_valid), .res_fired, .res_last(out_last), .res_stall(out_stall)
  );

  // hold timer state
  htw_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_req_type, .in_timer_id,
    .in_repeat_count(in_repeat_count), .in_interval, .res_ok, .scan_id
  );

  // a firing result is always ok
  assign out_ok          = res_fired | res_ok;
  assign out_fired       = res_fired;
  assign out_fired_timer = res_fired ? scan_id : 5'd0;
endmodule

// ----- src/htw_dp.sv -----
// Datapath of the timing wheel: timer memories, status flags, tick counter.
// Depends on htw_pkg.
module htw_dp import htw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_req_type,
  input  logic [4:0]  in_timer_id,
  input  logic [31:0] in_repeat_count,
  input  logic [31:0] in_interval,
  output logic        res_ok,
  output logic [4:0]  scan_id
);
  logic [63:0] expiry_mem [NumTimers];
  logic [31:0] period_mem [NumTimers];
  logic [31:0] left_mem [NumTimers];
  logic [32:0] pause_mem [NumTimers];
  tstat_t      status_r [NumTimers];

  logic [63:0] tick_r;
  logic [2:0]  type_r;
  logic [4:0]  id_r;
  logic [31:0] cnt_r, ivl_r;
  logic [4:0]  idx_r;
  logic [63:0] exp_q;
  logic [31:0] per_q, left_q;
  logic [32:0] pau_q;
  logic        ok_r;
  logic [4:0]  rd_addr;
  logic [63:0] next_tick;
  logic [31:0] left_dec;
  logic        req_ok;

  assign rd_addr   = cmd.scan_rd ? idx_r : id_r;
  assign next_tick = tick_r + 64'd1;
  assign left_dec  = left_q - 32'd1;
  assign sts.is_tick   = (type_r == REQ_TICK);
  assign sts.hit       = (status_r[idx_r] == ST_RUN) && (exp_q == tick_r);
  assign sts.scan_last = (idx_r == 5'(NumTimers - 1));
  assign res_ok  = ok_r;
  assign scan_id = idx_r;

  // decide whether the latched request succeeds
  always_comb begin
    case (type_r)
      REQ_ADD:    req_ok = status_r[id_r] == ST_IDLE && cnt_r != '0 &&
                           {1'b0, ivl_r} <= Horizon;
      REQ_KILL:   req_ok = status_r[id_r] != ST_IDLE;
      REQ_PAUSE:  req_ok = status_r[id_r] == ST_RUN;
      REQ_RESUME: req_ok = status_r[id_r] == ST_PAUSE;
      default:    req_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= in_req_type;
      id_r   <= in_timer_id;
      cnt_r  <= in_repeat_count;
      ivl_r  <= in_interval;
    end
    if (cmd.rd || cmd.scan_rd) begin
      exp_q  <= expiry_mem[rd_addr];
      per_q  <= period_mem[rd_addr];
      left_q <= left_mem[rd_addr];
      pau_q  <= pause_mem[rd_addr];
    end
    if (cmd.exec) begin
      case (type_r)
        REQ_ADD: if (status_r[id_r] == ST_IDLE && cnt_r != '0 && {1'b0, ivl_r} <= Horizon) begin
          left_mem[id_r]   <= cnt_r;
          period_mem[id_r] <= ivl_r;
          expiry_mem[id_r] <= tick_r + {32'd0, ivl_r};
        end
        REQ_PAUSE: if (status_r[id_r] == ST_RUN)
          pause_mem[id_r] <= 33'(exp_q - tick_r);
        REQ_RESUME: if (status_r[id_r] == ST_PAUSE)
          expiry_mem[id_r] <= tick_r + {31'd0, pau_q};
        default: ;
      endcase
    end
    if (cmd.scan_do && sts.hit) begin
      if (!left_q[31]) left_mem[idx_r] <= left_dec;
      expiry_mem[idx_r] <= next_tick + {32'd0, per_q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      idx_r  <= '0;
      ok_r   <= 1'b0;
      for (int i = 0; i < NumTimers; i++) status_r[i] <= ST_IDLE;
    end else begin
      if (cmd.capture) idx_r <= '0;
      if (cmd.scan_inc) idx_r <= idx_r + 5'd1;
      if (cmd.tick_done) begin
        tick_r <= next_tick;
        ok_r   <= 1'b1;
      end
      if (cmd.scan_do && sts.hit && !left_q[31] && left_dec == '0)
        status_r[idx_r] <= ST_IDLE;
      if (cmd.exec) begin
        ok_r <= req_ok;
        if (req_ok) begin
          case (type_r)
            REQ_ADD:    status_r[id_r] <= ST_RUN;
            REQ_KILL:   status_r[id_r] <= ST_IDLE;
            REQ_PAUSE:  status_r[id_r] <= ST_PAUSE;
            REQ_RESUME: status_r[id_r] <= ST_RUN;
            default: ;
          endcase
        end
      end
    end
  end

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_done |=> tick_r == $past(tick_r) + 64'd1)
    else $error("tick counter did not advance");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.scan_do))
    else $error("request and scan in same cycle");
  a_hold_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> $stable(tick_r))
    else $error("request changed tick counter");
endmodule

// ----- src/htw_ctrl.sv -----
// Controller state machine of the timing wheel.
// Depends on htw_pkg.
module htw_ctrl import htw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd,
  input  logic in_valid,
  output logic in_stall,
  output logic res_valid,
  output logic res_fired,
  output logic res_last,
  input  logic res_stall
);
  cstate_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    res_valid = 1'b0;
    res_fired = 1'b0;
    res_last = 1'b0;
    case (state_r)
      C_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = C_RD;
        end
      end
      C_RD: begin
        if (sts.is_tick) begin
          cmd.scan_rd = 1'b1;
          state_nxt = C_SCAN;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = C_EXEC;
        end
      end
      C_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = C_DONE;
      end
      C_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = C_SCAN;
      end
      C_SCAN: begin
        if (sts.hit) begin
          res_valid = 1'b1;
          res_fired = 1'b1;
          if (!res_stall) begin
            cmd.scan_do = 1'b1;
            state_nxt = C_OUT;
          end
        end else state_nxt = C_OUT;
      end
      C_OUT: begin
        if (sts.scan_last) begin
          cmd.tick_done = 1'b1;
          state_nxt = C_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt = C_SCAN_RD;
        end
      end
      C_DONE: begin
        res_valid = 1'b1;
        res_last = 1'b1;
        if (!res_stall) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == C_RD)
    else $error("capture not followed by read");
  a_fire_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_do |-> state_r == C_SCAN && sts.hit)
    else $error("fire outside scan");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_DONE && res_stall) |=> state_r == C_DONE)
    else $error("closing result dropped");
endmodule

// ----- tb/tb_hierarchical_timing_wheel.sv -----
// Self-checking testbench for hierarchical_timing_wheel: random and directed
// timer requests, a behavioral timer predictor, and result checking.
// Depends on htw_pkg and the hierarchical_timing_wheel RTL.
module tb_hierarchical_timing_wheel;
  import htw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  req_type;
    logic [4:0]  timer_id;
    logic [31:0] repeat_count;
    logic [31:0] interval;
  } request_s;

  typedef struct {
    logic       ok;
    logic       fired;
    logic [4:0] fired_timer;
    logic       last;
  } result_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [4:0] in_timer_id = '0;
  logic signed [31:0] in_repeat_count = '0;
  logic [31:0] in_interval = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic out_fired;
  logic [4:0] out_fired_timer;
  logic out_last;

  hierarchical_timing_wheel dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a mirror of the timer table.
  logic [63:0] now_tick;
  tstat_t      status_q [NumTimers];
  logic [63:0] expiry_q [NumTimers];
  logic [31:0] period_q [NumTimers];
  logic [31:0] left_q [NumTimers];
  logic [32:0] remain_q [NumTimers];

  request_s pending_reqs[$];
  result_s  expected_results[$];
  int unsigned errors = 0;
  bit calm = 0;  // long stretch with no idling on either side

  task automatic report(input string what);
    errors++;
    $display("mismatch #%0d at %0t: %s", errors, $realtime, what);
  endtask

  function automatic void push_result(logic ok, logic fired, logic [4:0] id, logic last);
    result_s r;
    r.ok = ok; r.fired = fired; r.fired_timer = id; r.last = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Advance the timer table by one accepted request and queue its results.
  function automatic void predict_timers(request_s rq);
    logic [63:0] nxt;
    logic ok;
    int id;
    id = rq.timer_id;
    ok = 1'b0;
    if (rq.req_type == REQ_TICK) begin
      nxt = now_tick + 64'd1;
      for (int i = 0; i < NumTimers; i++) begin
        if (status_q[i] == ST_RUN && expiry_q[i] == now_tick) begin
          push_result(1'b1, 1'b1, i[4:0], 1'b0);
          if (!left_q[i][31]) begin
            left_q[i] = left_q[i] - 32'd1;
            if (left_q[i] == 32'd0) begin
              status_q[i] = ST_IDLE;
              continue;
            end
          end
          expiry_q[i] = nxt + 64'(period_q[i]);
        end
      end
      now_tick = nxt;
      push_result(1'b1, 1'b0, 5'd0, 1'b1);
      return;
    end
    if (id < NumTimers) begin
      case (rq.req_type)
        REQ_ADD: begin
          if (rq.repeat_count != 0 && status_q[id] == ST_IDLE &&
              {1'b0, rq.interval} <= Horizon) begin
            status_q[id] = ST_RUN;
            left_q[id] = rq.repeat_count;
            period_q[id] = rq.interval;
            expiry_q[id] = now_tick + 64'(rq.interval);
            ok = 1'b1;
          end
        end
        REQ_KILL: begin
          if (status_q[id] != ST_IDLE) begin
            status_q[id] = ST_IDLE;
            ok = 1'b1;
          end
        end
        REQ_PAUSE: begin
          if (status_q[id] == ST_RUN) begin
            remain_q[id] = 33'(expiry_q[id] - now_tick);
            status_q[id] = ST_PAUSE;
            ok = 1'b1;
          end
        end
        REQ_RESUME: begin
          if (status_q[id] == ST_PAUSE) begin
            expiry_q[id] = now_tick + 64'(remain_q[id]);
            status_q[id] = ST_RUN;
            ok = 1'b1;
          end
        end
        default: ok = 1'b0;
      endcase
    end
    push_result(ok, 1'b0, 5'd0, 1'b1);
  endfunction

  function automatic void queue_req(logic [2:0] t, logic [4:0] id, logic [31:0] cnt,
                                    logic [31:0] iv);
    request_s rq;
    rq.req_type = t; rq.timer_id = id; rq.repeat_count = cnt; rq.interval = iv;
    pending_reqs.insert(pending_reqs.size(), rq);
  endfunction

  // Driver: hold the payload while stalled, idle about 19% of the time.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          request_s rq;
          rq = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= rq.req_type;
          in_timer_id <= rq.timer_id;
          in_repeat_count <= rq.repeat_count;
          in_interval <= rq.interval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict on each input transfer; check each output transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        request_s rq;
        rq.req_type = in_req_type; rq.timer_id = in_timer_id;
        rq.repeat_count = in_repeat_count; rq.interval = in_interval;
        predict_timers(rq);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result with no expectation");
        end else begin
          result_s e;
          e = expected_results.pop_front();
          if (out_ok !== e.ok)
            report($sformatf("ok got %b want %b", out_ok, e.ok));
          if (out_fired !== e.fired)
            report($sformatf("fired got %b want %b", out_fired, e.fired));
          if (out_fired_timer !== e.fired_timer)
            report($sformatf("fired_timer got %0d want %0d", out_fired_timer,
                             e.fired_timer));
          if (out_last !== e.last)
            report($sformatf("last got %b want %b", out_last, e.last));
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
    end
  end

  // Random add with mostly short intervals so timers actually fire.
  function automatic void random_add();
    logic [31:0] iv, cnt;
    int k;
    k = $urandom_range(99);
    iv = (k < 85) ? $urandom_range(6) : (k < 93) ? $urandom : 32'($urandom_range(40));
    k = $urandom_range(99);
    cnt = (k < 20) ? 32'hffff_ffff : (k < 25) ? 32'($urandom) | 32'h8000_0000 :
          (k < 30) ? 32'd0 : (k < 33) ? 32'h7fff_ffff : 32'($urandom_range(4, 1));
    queue_req(REQ_ADD, 5'($urandom_range(31)), cnt, iv);
  endfunction

  initial begin
    int k;
    now_tick = '0;
    for (int i = 0; i < NumTimers; i++) status_q[i] = ST_IDLE;
    // Directed: extremes, every request type, refusal cases.
    queue_req(REQ_ADD, 5'd0, 32'd1, 32'd0);            // zero interval
    queue_req(REQ_ADD, 5'd31, 32'hffff_ffff, 32'd0);   // forever
    queue_req(REQ_ADD, 5'd31, 32'd1, 32'd3);           // already running
    queue_req(REQ_ADD, 5'd5, 32'd0, 32'd2);            // count zero
    queue_req(REQ_ADD, 5'd6, 32'h8000_0000, 32'hffff_ffff); // max interval, negative
    queue_req(REQ_ADD, 5'd7, 32'h7fff_ffff, 32'd2);
    queue_req(REQ_TICK, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(REQ_TICK, 5'd0, 32'd0, 32'd0);
    queue_req(REQ_PAUSE, 5'd7, 32'd0, 32'd0);
    queue_req(REQ_PAUSE, 5'd7, 32'd0, 32'd0);          // already paused
    queue_req(REQ_TICK, 5'd0, 32'd0, 32'd0);
    queue_req(REQ_RESUME, 5'd7, 32'd0, 32'd0);
    queue_req(REQ_RESUME, 5'd7, 32'd0, 32'd0);         // not paused
    queue_req(REQ_KILL, 5'd6, 32'd0, 32'd0);
    queue_req(REQ_KILL, 5'd6, 32'd0, 32'd0);           // already idle
    queue_req(3'd5, 5'd1, 32'd1, 32'd1);               // unknown request
    queue_req(3'd7, 5'd2, 32'd1, 32'd1);
    queue_req(3'd6, 5'd2, 32'd1, 32'd1);
    queue_req(REQ_TICK, 5'd0, 32'd0, 32'd0);
    queue_req(REQ_TICK, 5'd0, 32'd0, 32'd0);
    queue_req(REQ_KILL, 5'd31, 32'd0, 32'd0);
    queue_req(REQ_KILL, 5'd7, 32'd0, 32'd0);
    // Random: weighted toward adds and ticks so timers fire often.
    for (int n = 0; n < 270; n++) begin
      k = $urandom_range(99);
      if (k < 30) random_add();
      else if (k < 65) queue_req(REQ_TICK, 5'($urandom), $urandom, $urandom);
      else if (k < 75) queue_req(REQ_KILL, 5'($urandom), $urandom, $urandom);
      else if (k < 85) queue_req(REQ_PAUSE, 5'($urandom), $urandom, $urandom);
      else if (k < 95) queue_req(REQ_RESUME, 5'($urandom), $urandom, $urandom);
      else queue_req(3'($urandom_range(7, 5)), 5'($urandom), $urandom, $urandom);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Run one stretch of the random part with no idling.
    wait (pending_reqs.size() < 150);
    calm = 1;
    wait (pending_reqs.size() < 100);
    calm = 0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[hierarchical_timing_wheel] OK");
    end else begin
      $display("[hierarchical_timing_wheel] ERROR");
    end
    $finish;
  end

  // Timeout: about 300 items, each with up to 33 results and a full scan, times a margin.
  initial begin
    #5ms;
    $display("[hierarchical_timing_wheel] ERROR");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/htw_pkg.sv
src/htw_dp.sv
src/htw_ctrl.sv
src/hierarchical_timing_wheel.sv
tb/tb_hierarchical_timing_wheel.sv
